// File: sv/mbp_pkg.sv
`default_nettype none

package mbp_pkg;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 12;
  localparam int SIDE_W     = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [FW_W-1:0]   FW_RESET     = 12'd640;
  localparam logic [FH_W-1:0]   FH_RESET     = 13'd480;
  localparam logic [FH_W-1:0]   HEIGHT_LIMIT = 13'd4096;
  localparam logic [SIDE_W-1:0] SIDE_START   = 7'd16;
  localparam logic [SIDE_W-1:0] SIDE_TOP     = 7'd63;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM  = 7'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  function automatic logic [7:0] avg8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    sum  = {1'b0, a} + {1'b0, b};
    avg8 = sum[8:1];
  endfunction

endpackage

`default_nettype wire

// File: sv/mbp_if.sv
`default_nettype none

interface mbp_pix_if import mbp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_blue;
  logic [7:0] in_green;
  logic [7:0] in_red;

  modport source (output valid, output in_blue, output in_green, output in_red,
                  input ready);
  modport sink   (input valid, input in_blue, input in_green, input in_red,
                  output ready);
endinterface

interface mbp_res_if import mbp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic       frame_done;

  modport source (output valid, output out_blue, output out_green, output out_red,
                  output frame_done, input ready);
  modport sink   (input valid, input out_blue, input out_green, input out_red,
                  input frame_done, output ready);
endinterface

interface mbp_cfg_if import mbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/mosaic_blend_pulsing_block.sv
`default_nettype none
// Pulsing mosaic blend on a BGR raster pixel stream.
//
// in_ch  : one pixel word per handshake (in_blue/in_green/in_red), raster order.
// out_ch : one result word per input word: the per-channel floor average of
//          the pixel and its block's top-left (anchor) pixel, plus frame_done
//          on the last pixel of each frame.
// cfg_ch : register writes, index 0 = frame_width, index 1 = frame_height.
//          Write only while the pipe is empty; always ready out of reset.
//
// Throughput: one word per cycle unless out_ch stalls. Stage 1 is the
// single-port anchor memory read (registered data), stage 2 the averaging
// adders feeding the output register, which drives out_ch.valid.
// in_ch.ready drops only when both stages hold words and out_ch is stalled;
// a stalled result holds steady while one more word is taken into stage 1.
//
// Anchors: one memory entry per block column, written as the first row of
// each block row passes, read back for the rows below. A pixel that is its
// own anchor is bypassed, so the memory needs no clearing pass after reset.
// Block side starts at 16, steps by one per frame up to 64, down to 1, back.
// Reset (rst_n low, synchronous): counters cleared, 640x480, side 16 rising,
// both stages empty; ready signals are low while reset is held.

module mosaic_blend_pulsing_block import mbp_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  mbp_pix_if.sink    in_ch,
  mbp_res_if.source  out_ch,
  mbp_cfg_if.sink    cfg_ch
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam logic [CW:0] MaxW = (CW+1)'(MAX_WIDTH);

  // config registers
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;

  // raster position
  logic [CW-1:0]     col_pos_r;
  logic [ROW_W-1:0]  row_pos_r;
  logic [SIDE_W-1:0] col_in_blk_r;
  logic [SIDE_W-1:0] row_in_blk_r;
  logic [CW-1:0]     blk_col_r;
  logic [SIDE_W-1:0] side_r;
  logic              growing_r;

  // pipe
  logic   s1_valid_r, s1_hit_r, s1_done_r;
  pixel_t s1_pix_r, s1_anchor_r;
  logic   out_valid_r, out_done_r;
  pixel_t out_pix_r;

  pixel_t anchor_mem [MAX_WIDTH];

  logic        in_acc, cfg_acc, adv_out;
  logic [CW:0] w_eff;
  logic [FH_W-1:0] h_eff;
  logic        last_col, last_row, anchor_we;
  pixel_t      in_pix, anchor_sel;

  assign adv_out      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = rst_n && (!s1_valid_r || adv_out);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = rst_n;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;

  assign in_pix.red   = in_ch.in_red;
  assign in_pix.green = in_ch.in_green;
  assign in_pix.blue  = in_ch.in_blue;

  // effective frame size, clipped
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = MaxW;
    end else begin
      w_eff = (CW+1)'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = FH_W'(1);
    end else if (frame_height_r > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = frame_height_r;
    end
  end

  assign last_col  = ({1'b0, col_pos_r} + (CW+1)'(1)) >= w_eff;
  assign last_row  = ({1'b0, row_pos_r} + FH_W'(1)) >= h_eff;
  assign anchor_we = (row_in_blk_r == '0) && (col_in_blk_r == '0);

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
    end else if (cfg_acc) begin
      unique case (reg_idx_t'(cfg_ch.index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_ch.data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_ch.data;
      endcase
    end
  end

  // raster counters and side bounce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r    <= '0;
      row_pos_r    <= '0;
      col_in_blk_r <= '0;
      row_in_blk_r <= '0;
      blk_col_r    <= '0;
      side_r       <= SIDE_START;
      growing_r    <= 1'b1;
    end else if (in_acc) begin
      if (!last_col) begin
        col_pos_r <= col_pos_r + CW'(1);
        if ((col_in_blk_r + SIDE_W'(1)) >= side_r) begin
          col_in_blk_r <= '0;
          blk_col_r    <= blk_col_r + CW'(1);
        end else begin
          col_in_blk_r <= col_in_blk_r + SIDE_W'(1);
        end
      end else begin
        col_pos_r    <= '0;
        col_in_blk_r <= '0;
        blk_col_r    <= '0;
        if (!last_row) begin
          row_pos_r <= row_pos_r + ROW_W'(1);
          if ((row_in_blk_r + SIDE_W'(1)) >= side_r) begin
            row_in_blk_r <= '0;
          end else begin
            row_in_blk_r <= row_in_blk_r + SIDE_W'(1);
          end
        end else begin
          row_pos_r    <= '0;
          row_in_blk_r <= '0;
          if (growing_r) begin
            side_r <= side_r + SIDE_W'(1);
            if ((side_r + SIDE_W'(1)) > SIDE_TOP) growing_r <= 1'b0;
          end else begin
            side_r <= side_r - SIDE_W'(1);
            if ((side_r - SIDE_W'(1)) < SIDE_BOTTOM) growing_r <= 1'b1;
          end
        end
      end
    end
  end

  // anchor memory, read-before-write; own-anchor pixels bypass it
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (anchor_we) anchor_mem[blk_col_r] <= in_pix;
      s1_anchor_r <= anchor_mem[blk_col_r];
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv_out) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r  <= in_pix;
      s1_hit_r  <= anchor_we;
      s1_done_r <= last_col && last_row;
    end
  end

  // stage 2: average into the output register
  assign anchor_sel = s1_hit_r ? s1_pix_r : s1_anchor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      out_pix_r.red   <= avg8(s1_pix_r.red,   anchor_sel.red);
      out_pix_r.green <= avg8(s1_pix_r.green, anchor_sel.green);
      out_pix_r.blue  <= avg8(s1_pix_r.blue,  anchor_sel.blue);
      out_done_r      <= s1_done_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_red    = out_pix_r.red;
  assign out_ch.out_green  = out_pix_r.green;
  assign out_ch.out_blue   = out_pix_r.blue;
  assign out_ch.frame_done = out_done_r;

endmodule

`default_nettype wire

// File: sv/mbp_checker.sv
`default_nettype none

module mbp_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_blue,
  input wire [7:0] out_green,
  input wire [7:0] out_red,
  input wire       frame_done
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // pipe comes up empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present right after reset");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_blue, out_green, out_red, frame_done}))
    else $error("stalled result word changed");

  // an accepted word reaches the output when the receiver is taking words
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc ##1 out_ready |=> out_valid)
    else $error("accepted word did not reach the output in two cycles");

  // no result word appears without an accepted input word
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result word appeared without an input word");

endmodule

bind mosaic_blend_pulsing_block mbp_checker u_mbp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_blue   (out_ch.out_blue),
  .out_green  (out_ch.out_green),
  .out_red    (out_ch.out_red),
  .frame_done (out_ch.frame_done)
);

`default_nettype wire
